[design/sfp_pkg.sv]
// Shared types and constants for the serial frame parser.
package sfp_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int IDX_W  = 6;

   // configuration register indexes
   localparam logic CSR_HEAD_BYTE   = 1'b0;
   localparam logic CSR_MAX_PAYLOAD = 1'b1;

   localparam logic [BYTE_W-1:0] HEAD_BYTE_RESET   = 8'd239;
   localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 7'd64;

   typedef struct packed {
      logic [BYTE_W-1:0] device_id;
      logic [BYTE_W-1:0] system_id;
      logic [BYTE_W-1:0] message_id;
      logic [BYTE_W-1:0] sequence_res;
      logic [LEN_W-1:0]  payload_length;
   } frame_info_type;

endpackage

[design/sfp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sfp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/sfp_rx.sv]
// Receive side: head hunt, header capture, payload store writes, checksum check.
module sfp_rx #(
   parameter int MAX_PAYLOAD_BYTES = 64,
   parameter int ADDR_W            = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_accept,
   input  logic [sfp_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [sfp_pkg::BYTE_W-1:0]    head_byte,
   input  logic [sfp_pkg::LEN_W-1:0]     max_payload,
   output logic                          wr_en,
   output logic [ADDR_W-1:0]             wr_addr,
   output logic [sfp_pkg::BYTE_W-1:0]    wr_data,
   output sfp_pkg::frame_info_type       info,
   output logic                          frame_good
);

   import sfp_pkg::*;

   localparam logic [2:0] PH_HUNT     = 3'd0;
   localparam logic [2:0] PH_DEVICE   = 3'd1;
   localparam logic [2:0] PH_SYSTEM   = 3'd2;
   localparam logic [2:0] PH_MESSAGE  = 3'd3;
   localparam logic [2:0] PH_SEQUENCE = 3'd4;
   localparam logic [2:0] PH_LENGTH   = 3'd5;
   localparam logic [2:0] PH_PAYLOAD  = 3'd6;
   localparam logic [2:0] PH_CHECK    = 3'd7;

   localparam logic [BYTE_W:0] MAX_LEN = (BYTE_W+1)'(MAX_PAYLOAD_BYTES);

   logic [2:0]        phase_ff, phase_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   frame_info_type    info_ff, info_in;
   logic [LEN_W-1:0]  count_inc;
   logic              len_too_long;

   assign count_inc    = count_ff + LEN_W'(1);
   assign len_too_long = ({1'b0, rx_byte} > {2'b00, max_payload}) ||
                         ({1'b0, rx_byte} > MAX_LEN);

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      info_in    = info_ff;
      wr_en      = 1'b0;
      frame_good = 1'b0;
      if (byte_accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == head_byte) begin
                  sum_in   = rx_byte;
                  count_in = '0;
                  phase_in = PH_DEVICE;
               end
            end
            PH_DEVICE: begin
               info_in.device_id = rx_byte;
               sum_in            = sum_ff + rx_byte;
               phase_in          = PH_SYSTEM;
            end
            PH_SYSTEM: begin
               info_in.system_id = rx_byte;
               sum_in            = sum_ff + rx_byte;
               phase_in          = PH_MESSAGE;
            end
            PH_MESSAGE: begin
               info_in.message_id = rx_byte;
               sum_in             = sum_ff + rx_byte;
               phase_in           = PH_SEQUENCE;
            end
            PH_SEQUENCE: begin
               info_in.sequence_res = rx_byte;
               sum_in               = sum_ff + rx_byte;
               phase_in             = PH_LENGTH;
            end
            PH_LENGTH: begin
               if (rx_byte == '0) begin
                  info_in.payload_length = '0;
                  phase_in               = PH_CHECK;
               end else if (len_too_long) begin
                  count_in = '0;
                  phase_in = PH_HUNT;
               end else begin
                  info_in.payload_length = rx_byte[LEN_W-1:0];
                  sum_in                 = sum_ff + rx_byte;
                  count_in               = '0;
                  phase_in               = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               wr_en  = 1'b1;
               sum_in = sum_ff + rx_byte;
               if (count_inc >= info_ff.payload_length) begin
                  count_in = '0;
                  phase_in = PH_CHECK;
               end else begin
                  count_in = count_inc;
               end
            end
            default: begin
               // checksum byte; a mismatch just goes back to hunting
               count_in   = '0;
               phase_in   = PH_HUNT;
               frame_good = (rx_byte == sum_ff);
            end
         endcase
      end
   end

   assign wr_addr = ADDR_W'(count_ff);
   assign wr_data = rx_byte;
   assign info    = info_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      sum_ff  <= sum_in;
      info_ff <= info_in;
   end

endmodule

[design/sfp_tx.sv]
// Readout sequencer: walks the payload store and drives the result register.
module sfp_tx #(
   parameter int ADDR_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          frame_good,
   input  sfp_pkg::frame_info_type       info,
   output logic                          busy,
   output logic                          rd_en,
   output logic [ADDR_W-1:0]             rd_addr,
   input  logic [sfp_pkg::BYTE_W-1:0]    rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sfp_pkg::frame_info_type       rsp_info,
   output logic [sfp_pkg::IDX_W-1:0]     rsp_byte_index,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                          rsp_has_payload,
   output logic                          rsp_last
);

   import sfp_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SHOW  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic              load_data, load_empty;
   logic              rsp_accept;
   frame_info_type    info_ff;
   logic [IDX_W-1:0]  index_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              has_ff;
   logic              last_ff;
   logic [LEN_W-1:0]  idx_inc;

   assign rsp_accept = (state_ff == ST_SHOW) && !rsp_stall;
   assign idx_inc    = idx_ff + LEN_W'(1);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      rd_en      = 1'b0;
      rd_addr    = ADDR_W'(idx_ff);
      load_data  = 1'b0;
      load_empty = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (frame_good) begin
               if (info.payload_length == '0) begin
                  load_empty = 1'b1;
                  state_in   = ST_SHOW;
               end else begin
                  idx_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            load_data = 1'b1;
            state_in  = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_accept) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  rd_en    = 1'b1;
                  rd_addr  = ADDR_W'(idx_inc);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      if (load_empty) begin
         info_ff  <= info;
         index_ff <= '0;
         byte_ff  <= '0;
         has_ff   <= 1'b0;
         last_ff  <= 1'b1;
      end else if (load_data) begin
         info_ff  <= info;
         index_ff <= idx_ff[IDX_W-1:0];
         byte_ff  <= rd_data;
         has_ff   <= 1'b1;
         last_ff  <= (idx_inc == info.payload_length);
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_SHOW);
   assign rsp_info         = info_ff;
   assign rsp_byte_index   = index_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_has_payload  = has_ff;
   assign rsp_last         = last_ff;

endmodule

[design/serial_frame_parser_sum_check.sv]
// Top level of the serial frame parser with additive checksum.
// Header and payload bytes are taken one per cycle (req_stall low). Once the
// checksum byte matches, req_stall rises and the frame is read back from the
// payload RAM: each payload beat is a RAM read followed by a load of the result
// register, and rsp_stall can hold it; an empty frame gives its single beat in
// the cycle after the checksum byte. A frame of N payload bytes is 6 + N + 1
// input bytes, and input stays stalled until its last beat is accepted.
// Configuration writes to head_byte and max_payload take effect on the next
// byte; the payload RAM needs no clearing after reset.
module serial_frame_parser_sum_check #(
   parameter int MAX_PAYLOAD_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sfp_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_device_id,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_system_id,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_message_id,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_sequence_res,
   output logic [sfp_pkg::LEN_W-1:0]     rsp_payload_length,
   output logic [sfp_pkg::IDX_W-1:0]     rsp_byte_index,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                          rsp_has_payload,
   output logic                          rsp_last,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [sfp_pkg::BYTE_W-1:0]    csr_wdata
);

   import sfp_pkg::*;

   localparam int ADDR_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

   logic [BYTE_W-1:0] head_ff;
   logic [LEN_W-1:0]  max_len_ff;
   logic              req_accept;
   logic              tx_busy;
   logic              frame_good;
   frame_info_type    info;
   frame_info_type    out_info;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= HEAD_BYTE_RESET;
         max_len_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HEAD_BYTE:   head_ff    <= csr_wdata;
            CSR_MAX_PAYLOAD: max_len_ff <= csr_wdata[LEN_W-1:0];
            default:         head_ff    <= head_ff;
         endcase
      end
   end

   // input waits while a frame is being read out of the store
   assign req_stall  = tx_busy;
   assign req_accept = req_valid && !req_stall;

   sfp_rx #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
      .ADDR_W            (ADDR_W)
   ) u_rx (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept),
      .rx_byte     (req_rx_byte),
      .head_byte   (head_ff),
      .max_payload (max_len_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .info        (info),
      .frame_good  (frame_good)
   );

   sfp_ram #(
      .WIDTH  (BYTE_W),
      .DEPTH  (MAX_PAYLOAD_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfp_tx #(
      .ADDR_W (ADDR_W)
   ) u_tx (
      .clock            (clock),
      .reset            (reset),
      .frame_good       (frame_good),
      .info             (info),
      .busy             (tx_busy),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_info         (out_info),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_last         (rsp_last)
   );

   assign rsp_device_id      = out_info.device_id;
   assign rsp_system_id      = out_info.system_id;
   assign rsp_message_id     = out_info.message_id;
   assign rsp_sequence_res   = out_info.sequence_res;
   assign rsp_payload_length = out_info.payload_length;

endmodule

[test/serial_frame_parser_sum_check_tb.sv]
// Testbench for the serial frame parser: directed frames, then random frames checked against a parser model.
module serial_frame_parser_sum_check_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfp_pkg::*;

   localparam int PAYLOAD_CAP  = 64;
   localparam int DRAIN_CYCLES = 200;
   localparam int SETTLE_LIMIT = 20000;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_BEATS  = 75;
   localparam int HOLD_CYCLES  = 400;

   typedef enum logic [2:0] {
      PH_HUNT, PH_DEVICE, PH_SYSTEM, PH_MESSAGE, PH_SEQ, PH_LENGTH, PH_PAYLOAD, PH_CHECKSUM
   } parse_phase_e;

   typedef enum int {FR_GOOD, FR_BAD_SUM, FR_TOO_LONG, FR_CUT, FR_NOISE} frame_kind_e;

   typedef struct packed {
      frame_info_type     info;
      logic [IDX_W-1:0]   idx;
      logic [BYTE_W-1:0]  data;
      logic               has;
      logic               last;
   } frame_beat_t;

   typedef struct {
      frame_kind_e        kind;
      logic [BYTE_W-1:0]  dev;
      logic [BYTE_W-1:0]  sys;
      logic [BYTE_W-1:0]  msg;
      logic [BYTE_W-1:0]  seq;
      int                 len;
      bit                 typed;
   } stim_row_t;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_device_id;
   logic [BYTE_W-1:0]    rsp_system_id;
   logic [BYTE_W-1:0]    rsp_message_id;
   logic [BYTE_W-1:0]    rsp_sequence_res;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic [IDX_W-1:0]     rsp_byte_index;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic                 rsp_has_payload;
   logic                 rsp_last;
   logic                 csr_write = 1'b0;
   logic                 csr_index = CSR_HEAD_BYTE;
   logic [BYTE_W-1:0]    csr_wdata = '0;

   // tags that travel with each input beat
   logic                 beat_end = 1'b0;
   logic                 beat_typed = 1'b0;
   logic                 typed_cnt = 1'b0;
   frame_beat_t          typed_rec = '0;

   serial_frame_parser_sum_check uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_device_id      (rsp_device_id),
      .rsp_system_id      (rsp_system_id),
      .rsp_message_id     (rsp_message_id),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_payload    (rsp_has_payload),
      .rsp_last           (rsp_last),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // parser model state
   logic [BYTE_W-1:0]    head_val = HEAD_BYTE_RESET;
   logic [LEN_W-1:0]     max_len = MAX_PAYLOAD_RESET;
   parse_phase_e         parse_phase = PH_HUNT;
   logic [BYTE_W-1:0]    dev_q = '0;
   logic [BYTE_W-1:0]    sys_q = '0;
   logic [BYTE_W-1:0]    msg_q = '0;
   logic [BYTE_W-1:0]    seq_q = '0;
   logic [LEN_W-1:0]     len_q = '0;
   logic [LEN_W-1:0]     pay_count = '0;
   logic [BYTE_W-1:0]    sum_acc = '0;
   logic [BYTE_W-1:0]    pay_mem [PAYLOAD_CAP];

   frame_beat_t          pending_beats [$];
   int                   mismatches = 0;
   int                   cycle_count = 0;

   // stimulus side
   logic [BYTE_W-1:0]    cfg_head = HEAD_BYTE_RESET;
   logic [LEN_W-1:0]     cfg_max = MAX_PAYLOAD_RESET;
   logic [BYTE_W-1:0]    frame_bytes [$];
   int                   split_at = 0;
   int                   beats_sent = 0;
   int                   tx_idle_pct = 0;
   int                   rx_idle_pct = 0;
   bit                   hold_start = 1'b0;
   bit                   hold_taken = 1'b0;
   int                   hold_left = 0;

   function automatic void note_config(logic idx, logic [BYTE_W-1:0] data);
      if (idx == CSR_HEAD_BYTE) head_val = data;
      else max_len = data[LEN_W-1:0];
   endfunction

   // advances the parser model by one byte; queues the frame on a checksum match when emit is set
   function automatic void parse_byte(logic [BYTE_W-1:0] b, bit emit);
      frame_beat_t r;
      case (parse_phase)
         PH_HUNT: begin
            if (b == head_val) begin
               sum_acc = b;
               pay_count = '0;
               parse_phase = PH_DEVICE;
            end
         end
         PH_DEVICE: begin
            dev_q = b;
            sum_acc += b;
            parse_phase = PH_SYSTEM;
         end
         PH_SYSTEM: begin
            sys_q = b;
            sum_acc += b;
            parse_phase = PH_MESSAGE;
         end
         PH_MESSAGE: begin
            msg_q = b;
            sum_acc += b;
            parse_phase = PH_SEQ;
         end
         PH_SEQ: begin
            seq_q = b;
            sum_acc += b;
            parse_phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (b == 0) begin
               len_q = '0;
               parse_phase = PH_CHECKSUM;
            end else if (b > max_len || b > PAYLOAD_CAP) begin
               parse_phase = PH_HUNT;
               pay_count = '0;
            end else begin
               len_q = b[LEN_W-1:0];
               sum_acc += b;
               pay_count = '0;
               parse_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            pay_mem[pay_count[IDX_W-1:0]] = b;
            sum_acc += b;
            pay_count++;
            if (pay_count >= len_q) begin
               pay_count = '0;
               parse_phase = PH_CHECKSUM;
            end
         end
         default: begin
            parse_phase = PH_HUNT;
            pay_count = '0;
            if (b == sum_acc && emit) begin
               r.info.device_id = dev_q;
               r.info.system_id = sys_q;
               r.info.message_id = msg_q;
               r.info.sequence_res = seq_q;
               r.info.payload_length = len_q;
               if (len_q == 0) begin
                  r.idx = '0;
                  r.data = '0;
                  r.has = 1'b0;
                  r.last = 1'b1;
                  pending_beats.push_back(r);
               end else begin
                  for (int k = 0; k < len_q; k++) begin
                     r.idx = IDX_W'(k);
                     r.data = pay_mem[k];
                     r.has = 1'b1;
                     r.last = (k == len_q - 1);
                     pending_beats.push_back(r);
                  end
               end
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_beat(frame_beat_t want);
      if (rsp_device_id != want.info.device_id)
         report_mismatch("device_id", rsp_device_id, want.info.device_id);
      if (rsp_system_id != want.info.system_id)
         report_mismatch("system_id", rsp_system_id, want.info.system_id);
      if (rsp_message_id != want.info.message_id)
         report_mismatch("message_id", rsp_message_id, want.info.message_id);
      if (rsp_sequence_res != want.info.sequence_res)
         report_mismatch("sequence_res", rsp_sequence_res, want.info.sequence_res);
      if (rsp_payload_length != want.info.payload_length)
         report_mismatch("payload_length", rsp_payload_length, want.info.payload_length);
      if (rsp_byte_index != want.idx)
         report_mismatch("byte_index", rsp_byte_index, want.idx);
      if (rsp_payload_byte != want.data)
         report_mismatch("payload_byte", rsp_payload_byte, want.data);
      if (rsp_has_payload != want.has)
         report_mismatch("has_payload", rsp_has_payload, want.has);
      if (rsp_last != want.last)
         report_mismatch("last", rsp_last, want.last);
   endtask

   // config writes, result checks and prediction, all sampled at the edge
   always @(posedge clock) begin : monitor
      if (!reset) begin
         if (csr_write) note_config(csr_index, csr_wdata);
         if (rsp_valid && !rsp_stall) begin
            if (pending_beats.size() == 0)
               report_mismatch("beat with nothing pending", rsp_payload_byte, -1);
            else
               check_beat(pending_beats.pop_front());
         end
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte, !beat_typed);
            if (beat_typed && beat_end && typed_cnt) pending_beats.push_back(typed_rec);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: random stall, plus one long hold-off so the block backs up
   initial begin
      forever begin
         @(posedge clock);
         if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   task automatic send_beat(logic [BYTE_W-1:0] b, bit is_end, bit typed, bit cnt,
                            frame_beat_t rec);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      beat_end <= is_end;
      beat_typed <= typed;
      typed_cnt <= cnt;
      typed_rec <= rec;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_range(int first, int stop_at, bit typed, bit cnt, frame_beat_t rec);
      for (int i = first; i < stop_at; i++)
         send_beat(frame_bytes[i], i == stop_at - 1, typed, cnt, rec);
   endtask

   task automatic build_frame(frame_kind_e kind, logic [BYTE_W-1:0] dev,
                              logic [BYTE_W-1:0] sys, logic [BYTE_W-1:0] msg,
                              logic [BYTE_W-1:0] seq, int len, bit fixed_pat);
      logic [BYTE_W-1:0] sum;
      int cut;
      frame_bytes.delete();
      if (kind == FR_NOISE) begin
         repeat ($urandom_range(1, 3)) frame_bytes.push_back(BYTE_W'($urandom_range(255)));
      end else begin
         frame_bytes = {cfg_head, dev, sys, msg, seq, BYTE_W'(len)};
         if (kind != FR_TOO_LONG) begin
            for (int k = 0; k < len; k++)
               frame_bytes.push_back(fixed_pat ? ((k % 2) ? 8'hFF : 8'h00)
                                               : BYTE_W'($urandom_range(255)));
            sum = '0;
            foreach (frame_bytes[i]) sum += frame_bytes[i];
            if (kind == FR_BAD_SUM) sum += BYTE_W'($urandom_range(1, 255));
            frame_bytes.push_back(sum);
            if (kind == FR_CUT) begin
               cut = $urandom_range(1, frame_bytes.size() - 1);
               while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
         end
      end
   endtask

   function automatic int pick_len(int limit);
      int r;
      r = $urandom_range(99);
      if (r < 5) return limit;
      if (r < 15) return 0;
      return $urandom_range(0, limit < 8 ? limit : 8);
   endfunction

   task automatic random_frame;
      int limit;
      int r;
      int len;
      frame_kind_e kind;
      limit = (cfg_max < PAYLOAD_CAP) ? cfg_max : PAYLOAD_CAP;
      r = $urandom_range(99);
      if (r < 70) kind = FR_GOOD;
      else if (r < 80) kind = FR_BAD_SUM;
      else if (r < 87) kind = FR_TOO_LONG;
      else if (r < 93) kind = FR_CUT;
      else kind = FR_NOISE;
      if (kind == FR_TOO_LONG) len = $urandom_range(limit + 1, 255);
      else len = pick_len(limit);
      build_frame(kind, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                  BYTE_W'($urandom), len, 1'b0);
      send_range(0, frame_bytes.size(), 1'b0, 1'b0, '0);
   endtask

   task automatic write_reg(logic idx, logic [BYTE_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_HEAD_BYTE) cfg_head = data;
      else cfg_max = data[LEN_W-1:0];
   endtask

   // wait until nothing is pending, then let any readout in flight finish
   task automatic settle;
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_beats.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      stim_row_t row_tab [4];
      logic [BYTE_W-1:0] head_tab [6];
      logic [BYTE_W-1:0] max_tab [6];
      frame_beat_t rec;
      int phase_end;

      // empty frame with extreme header bytes, an oversized length,
      // a bad checksum, then a short good frame
      row_tab[0] = '{FR_GOOD,     8'hFF, 8'h00, 8'hFF, 8'h00, 0,  1'b1};
      row_tab[1] = '{FR_TOO_LONG, 8'h00, 8'hFF, 8'h00, 8'hFF, 65, 1'b1};
      row_tab[2] = '{FR_BAD_SUM,  8'h5A, 8'hA5, 8'h01, 8'h80, 1,  1'b1};
      row_tab[3] = '{FR_GOOD,     8'h12, 8'h34, 8'h56, 8'h78, 2,  1'b0};

      // max_payload raw values: bit 7 is dropped by the 7-bit register
      head_tab = '{8'h00, 8'hFF, BYTE_W'($urandom), 8'hA5, BYTE_W'($urandom), 8'hEF};
      max_tab  = '{8'hFF, 8'h00, BYTE_W'($urandom_range(1, 64)), 8'hC0, 8'h01, 8'h40};

      tx_idle_pct = 10;
      rx_idle_pct = 80;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (row_tab[i]) begin
         build_frame(row_tab[i].kind, row_tab[i].dev, row_tab[i].sys, row_tab[i].msg,
                     row_tab[i].seq, row_tab[i].len, 1'b1);
         rec = '0;
         rec.info.device_id = row_tab[i].dev;
         rec.info.system_id = row_tab[i].sys;
         rec.info.message_id = row_tab[i].msg;
         rec.info.sequence_res = row_tab[i].seq;
         rec.last = 1'b1;
         send_range(0, frame_bytes.size(), row_tab[i].typed,
                    row_tab[i].typed && row_tab[i].kind == FR_GOOD, rec);
      end
      settle;

      for (int p = 0; p < 6; p++) begin
         if (p < 2) begin
            tx_idle_pct = 10;
            rx_idle_pct = 80;
         end else if (p < 4) begin
            tx_idle_pct = 80;
            rx_idle_pct = 10;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if (p % 2) begin
            write_reg(CSR_MAX_PAYLOAD, max_tab[p]);
            write_reg(CSR_HEAD_BYTE, head_tab[p]);
         end else begin
            write_reg(CSR_HEAD_BYTE, head_tab[p]);
            write_reg(CSR_MAX_PAYLOAD, max_tab[p]);
         end
         csr_write <= 1'b0;
         if (p == 0) hold_start = 1'b1;
         // finish the frame left half-sent before the register change
         if (split_at > 0) send_range(split_at, frame_bytes.size(), 1'b0, 1'b0, '0);
         split_at = 0;
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) random_frame;
         if (p < 5) begin
            build_frame(FR_GOOD, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                        BYTE_W'($urandom), $urandom_range(1, 8), 1'b0);
            split_at = $urandom_range(1, 5);
            send_range(0, split_at, 1'b0, 1'b0, '0);
         end
         settle;
      end

      if (pending_beats.size() != 0)
         report_mismatch("beats never delivered", 0, pending_beats.size());
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[serial_frame_parser_sum_check.f]
design/sfp_pkg.sv
design/sfp_ram.sv
design/sfp_rx.sv
design/sfp_tx.sv
design/serial_frame_parser_sum_check.sv
test/serial_frame_parser_sum_check_tb.sv
